@@ hw/rtl/gwm_pkg.sv @@
// Shared constants and types for the wildcard glob matcher.
package gwm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int STORE_BYTES = 32;
    localparam int LEN_W       = 6;
    localparam int POS_W       = STORE_BYTES + 1;
    localparam int WORD_W      = 64;
    localparam int NUM_WORDS   = STORE_BYTES / 8;
    localparam int CFG_IDX_W   = 3;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_8  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_16 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_24 = 3'd4;

    localparam logic [LEN_W-1:0] CAP_LEN =
        LEN_W'((MAX_PATTERN < STORE_BYTES) ? MAX_PATTERN : STORE_BYTES);

    typedef logic [STORE_BYTES-1:0][7:0] pat_bytes_t;
    typedef logic [POS_W-1:0]            pos_set_t;

    typedef struct packed {
        logic     hit;
        pos_set_t next;
    } step_res_t;

endpackage

@@ hw/rtl/gwm_step.sv @@
// Position-set update: star closure, end-of-name test and next set for one byte.
module gwm_step
(
    input  gwm_pkg::pat_bytes_t       pat,
    input  logic [gwm_pkg::LEN_W-1:0] eff_len,
    input  gwm_pkg::pos_set_t         cur,
    input  logic [7:0]                name_byte,
    output gwm_pkg::step_res_t        res
);

    gwm_pkg::pos_set_t pos_mask;
    gwm_pkg::pos_set_t star_mask;
    gwm_pkg::pos_set_t lit_ok;
    gwm_pkg::pos_set_t live;
    gwm_pkg::pos_set_t gen;
    gwm_pkg::pos_set_t sum;
    gwm_pkg::pos_set_t closed;
    gwm_pkg::pos_set_t nxt;

    always_comb
    begin
        for (int i = 0; i < gwm_pkg::POS_W; i++)
        begin
            pos_mask[i] = (gwm_pkg::LEN_W'(i) <= eff_len);
        end
        for (int i = 0; i < gwm_pkg::STORE_BYTES; i++)
        begin
            star_mask[i] = (gwm_pkg::LEN_W'(i) < eff_len) && (pat[i] == gwm_pkg::STAR_BYTE);
            lit_ok[i]    = (gwm_pkg::LEN_W'(i) < eff_len) && (pat[i] != gwm_pkg::STAR_BYTE)
                           && ((pat[i] == gwm_pkg::ANY_BYTE) || (pat[i] == name_byte));
        end
        star_mask[gwm_pkg::POS_W-1] = 1'b0;
        lit_ok[gwm_pkg::POS_W-1]    = 1'b0;
    end

    // closure through star runs is a carry chain: generate on active stars,
    // propagate across consecutive stars
    assign live   = cur & pos_mask;
    assign gen    = live & star_mask;
    assign sum    = gen + star_mask;
    assign closed = live | (sum ^ gen ^ star_mask);

    assign nxt = (closed & star_mask)
               | {(closed[gwm_pkg::POS_W-2:0] & lit_ok[gwm_pkg::POS_W-2:0]), 1'b0};

    assign res.hit  = closed[eff_len];
    assign res.next = nxt;

endmodule

@@ hw/rtl/wildcard_glob_matcher.sv @@
// Top level of the streamed glob matcher with '*' and '?'.
// An end-of-name word is staged, then its result is registered.
// Throughput: one word per cycle, but an end word waits on a stalled result; the
// position update is one 33-bit add plus per-position byte compares between the input
// register and the state/result registers. Reset: pattern length and bytes clear to 0,
// only the start position is active, and both pipeline registers are empty.
module wildcard_glob_matcher
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [gwm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gwm_pkg::WORD_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic [7:0]                      name_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            matched
);

    logic [gwm_pkg::LEN_W-1:0]                       len_reg;
    logic [gwm_pkg::NUM_WORDS-1:0][gwm_pkg::WORD_W-1:0] words_reg;
    gwm_pkg::pat_bytes_t                             pat;
    logic [gwm_pkg::LEN_W-1:0]                       eff_len;

    logic                     stg_valid_reg;
    logic                     stg_action_reg;
    logic [7:0]               stg_byte_reg;
    gwm_pkg::pos_set_t        active_reg;
    gwm_pkg::pos_set_t        active_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     matched_reg;
    logic                     advance;
    logic                     in_take;
    gwm_pkg::step_res_t       step;

    assign pat     = words_reg;
    assign eff_len = (len_reg > gwm_pkg::CAP_LEN) ? gwm_pkg::CAP_LEN : len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            words_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gwm_pkg::CFG_LENGTH:   len_reg      <= cfg_data[gwm_pkg::LEN_W-1:0];
                gwm_pkg::CFG_BYTES_0:  words_reg[0] <= cfg_data;
                gwm_pkg::CFG_BYTES_8:  words_reg[1] <= cfg_data;
                gwm_pkg::CFG_BYTES_16: words_reg[2] <= cfg_data;
                gwm_pkg::CFG_BYTES_24: words_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    gwm_step u_step
    (
        .pat       (pat),
        .eff_len   (eff_len),
        .cur       (active_reg),
        .name_byte (stg_byte_reg),
        .res       (step)
    );

    // an end word needs the result slot; a consume word always moves on
    assign advance  = stg_valid_reg && (!stg_action_reg || !out_valid_reg || !out_stall);
    assign in_stall = stg_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign active_next    = stg_action_reg ? gwm_pkg::POS_W'(1) : step.next;
    assign out_valid_next = (out_valid_reg && out_stall) || (advance && stg_action_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            active_reg    <= gwm_pkg::POS_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= in_take || (stg_valid_reg && !advance);
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stg_action_reg <= action;
            stg_byte_reg   <= name_byte;
        end
        if (advance && stg_action_reg)
        begin
            matched_reg <= step.hit;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

`ifndef NO_ASSERTIONS
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stg_action_reg) |=> (active_reg == gwm_pkg::POS_W'(1)))
        else $error("state not restarted after end word");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> stg_valid_reg)
        else $error("input stalled with empty stage");

    a_consume_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !stg_action_reg) |=> (out_valid_reg == $past(out_valid_reg && out_stall)))
        else $error("consume word produced a result");

    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && stg_action_reg))
        else $error("result without end word");
`endif

endmodule

@@ dv/wildcard_glob_matcher_test.sv @@
// Random and directed test of the streamed glob matcher against a bit-parallel position predictor.
class glob_match_board;
    logic [gwm_pkg::LEN_W-1:0] pat_len;
    gwm_pkg::pat_bytes_t       pat;
    gwm_pkg::pos_set_t         positions;
    logic                      expected_hits[$];
    int                        errors;

    function new();
        pat_len   = '0;
        pat       = '0;
        positions = gwm_pkg::POS_W'(1);
        errors    = 0;
    endfunction

    function int pending();
        return expected_hits.size();
    endfunction

    function void set_reg(logic [gwm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        int k;
        case (idx)
            gwm_pkg::CFG_LENGTH:   pat_len = data[gwm_pkg::LEN_W-1:0];
            gwm_pkg::CFG_BYTES_0:  k = 0;
            gwm_pkg::CFG_BYTES_8:  k = 1;
            gwm_pkg::CFG_BYTES_16: k = 2;
            gwm_pkg::CFG_BYTES_24: k = 3;
            default:               k = -1;
        endcase
        if (idx != gwm_pkg::CFG_LENGTH && k >= 0)
        begin
            for (int j = 0; j < 8; j++)
                pat[k*8+j] = data[j*8 +: 8];
        end
    endfunction

    function int eff_len();
        int n;
        n = pat_len;
        if (n > gwm_pkg::MAX_PATTERN) n = gwm_pkg::MAX_PATTERN;
        if (n > gwm_pkg::STORE_BYTES) n = gwm_pkg::STORE_BYTES;
        return n;
    endfunction

    // drop positions past the pattern end, then let stars pass through
    function gwm_pkg::pos_set_t closed(int n);
        gwm_pkg::pos_set_t s;
        s = positions;
        for (int i = 0; i < gwm_pkg::POS_W; i++)
            if (i > n) s[i] = 1'b0;
        for (int i = 0; i < n; i++)
            if (s[i] && pat[i] == gwm_pkg::STAR_BYTE) s[i+1] = 1'b1;
        return s;
    endfunction

    function void note_word(logic act, logic [7:0] b);
        int                n;
        gwm_pkg::pos_set_t cur;
        gwm_pkg::pos_set_t nxt;
        n   = eff_len();
        cur = closed(n);
        nxt = '0;
        if (act)
        begin
            expected_hits.push_back(cur[n]);
            positions = gwm_pkg::POS_W'(1);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                if (cur[i])
                begin
                    if (pat[i] == gwm_pkg::STAR_BYTE)
                        nxt[i] = 1'b1;
                    else if (pat[i] == gwm_pkg::ANY_BYTE || pat[i] == b)
                        nxt[i+1] = 1'b1;
                end
            end
            positions = nxt;
        end
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task check_result(logic m);
        logic want;
        if (expected_hits.size() == 0)
            report($sformatf("result word matched=%0b with nothing expected", m));
        else
        begin
            want = expected_hits.pop_front();
            if (m !== want)
                report($sformatf("matched %0b, expected %0b", m, want));
        end
    endtask
endclass

module wildcard_glob_matcher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS     = 1750;
    localparam int QUIET_AT  = 1450;
    localparam int STALL_MAX = 2000;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [gwm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gwm_pkg::WORD_W-1:0]    cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic                          action;
    logic [7:0]                    name_byte;
    logic                          out_valid;
    logic                          out_stall;
    logic                          matched;

    glob_match_board board;
    logic [7:0]      pbytes[gwm_pkg::STORE_BYTES];
    logic [7:0]      name_q[$];
    int              words_sent;
    int              idle_cycles;
    int              stall_left;
    bit              src_idle;
    bit              snk_idle;
    bit              quiet;

    wildcard_glob_matcher DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .name_byte (name_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .matched   (matched)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // results first, then the word accepted at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result(matched);
            if (in_valid && !in_stall)
                board.note_word(action, name_byte);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_MAX)
            begin
                $display("wildcard_glob_matcher_test: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && snk_idle && !quiet && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 18);
            out_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
        end
    end

    function logic [7:0] rand_char();
        case ($urandom_range(0, 5))
            0: return 8'h61;
            1: return 8'h62;
            2: return 8'h63;
            3: return gwm_pkg::STAR_BYTE;
            4: return gwm_pkg::ANY_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    task send_word(logic act, logic [7:0] b);
        int gap;
        if (src_idle && !quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 18);
            @(negedge clk);
            in_valid  <= 1'b0;
            action    <= 1'($urandom);
            name_byte <= 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        action    <= act;
        name_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    task send_name();
        foreach (name_q[i])
            send_word(1'b0, name_q[i]);
        send_word(1'b1, 8'($urandom));
    endtask

    // sender holds off until every result is back and the pipe is empty
    task drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_reg(logic [gwm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.set_reg(idx, data);
    endtask

    task cfg_release();
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task program_pattern(int len);
        logic [63:0] d;
        d = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0) d = '0;
        d[gwm_pkg::LEN_W-1:0] = gwm_pkg::LEN_W'(len);
        write_reg(gwm_pkg::CFG_LENGTH, d);
        for (int k = 0; k < gwm_pkg::NUM_WORDS; k++)
        begin
            for (int j = 0; j < 8; j++)
                d[j*8 +: 8] = pbytes[k*8+j];
            write_reg(gwm_pkg::CFG_IDX_W'(gwm_pkg::CFG_BYTES_0 + k), d);
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(gwm_pkg::CFG_IDX_W'($urandom_range(gwm_pkg::CFG_BYTES_24 + 1, 7)),
                      {$urandom, $urandom});
        cfg_release();
    endtask

    function int make_pattern();
        int r;
        int len;
        r = $urandom_range(0, 19);
        if (r == 0)      len = 0;
        else if (r == 1) len = 32;
        else if (r == 2) len = $urandom_range(33, 63);
        else             len = $urandom_range(1, 10);
        for (int i = 0; i < gwm_pkg::STORE_BYTES; i++)
        begin
            r = $urandom_range(0, 19);
            if (r < 5)       pbytes[i] = gwm_pkg::STAR_BYTE;
            else if (r < 8)  pbytes[i] = gwm_pkg::ANY_BYTE;
            else if (r < 18) pbytes[i] = 8'h61 + 8'($urandom_range(0, 2));
            else             pbytes[i] = 8'($urandom);
        end
        return len;
    endfunction

    // mostly names built from the pattern, some mutated, some pure noise
    function void make_name(int len);
        int n;
        int pos;
        n = (len > gwm_pkg::STORE_BYTES) ? gwm_pkg::STORE_BYTES : len;
        name_q.delete();
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(0, 8)) name_q.push_back(rand_char());
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                if (pbytes[i] == gwm_pkg::STAR_BYTE)
                    repeat ($urandom_range(0, 3)) name_q.push_back(rand_char());
                else if (pbytes[i] == gwm_pkg::ANY_BYTE)
                    name_q.push_back(8'($urandom));
                else
                    name_q.push_back(pbytes[i]);
            end
        end
        if ($urandom_range(0, 2) == 0 && name_q.size() > 0)
        begin
            pos = $urandom_range(0, name_q.size() - 1);
            case ($urandom_range(0, 2))
                0: name_q[pos] = rand_char();
                1: name_q.delete(pos);
                default: name_q.insert(pos, rand_char());
            endcase
        end
    endfunction

    task directed();
        // empty pattern after reset: only the empty name matches
        send_word(1'b1, 8'hFF);
        send_word(1'b0, 8'hFF);
        send_word(1'b1, 8'h00);
        drain();

        // zero byte literal, star, any
        foreach (pbytes[i]) pbytes[i] = 8'($urandom);
        pbytes[0] = 8'h00;
        pbytes[1] = gwm_pkg::STAR_BYTE;
        pbytes[2] = gwm_pkg::ANY_BYTE;
        program_pattern(3);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h80);
        send_word(1'b1, 8'h00);
        send_word(1'b1, 8'h00);
        send_word(1'b0, 8'h01);
        send_word(1'b1, 8'h00);
        drain();

        // length saturates at capacity; full run of stars
        foreach (pbytes[i]) pbytes[i] = gwm_pkg::STAR_BYTE;
        program_pattern(63);
        send_word(1'b1, 8'h5A);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h00);
        send_word(1'b1, 8'hA5);
        drain();

        // pattern shortened in the middle of a name
        foreach (pbytes[i]) pbytes[i] = 8'($urandom);
        pbytes[0] = 8'h61;
        pbytes[1] = 8'h62;
        program_pattern(2);
        send_word(1'b0, 8'h61);
        drain();
        write_reg(gwm_pkg::CFG_LENGTH, 64'(1));
        cfg_release();
        send_word(1'b1, 8'h00);
        drain();
    endtask

    initial
    begin
        int len;
        board      = new();
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        action     = 1'b0;
        name_byte  = '0;
        words_sent = 0;
        idle_cycles = 0;
        src_idle   = 1'b1;
        snk_idle   = 1'b1;
        quiet      = 1'b0;
        foreach (pbytes[i]) pbytes[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed();

        while (words_sent < ITEMS)
        begin
            quiet    = (words_sent > QUIET_AT);
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            drain();
            len = make_pattern();
            program_pattern(len);
            repeat ($urandom_range(4, 14))
            begin
                make_name(len);
                send_name();
            end
        end
        drain();
        repeat (8) @(posedge clk);

        if (board.errors == 0)
            $display("wildcard_glob_matcher_test: PASS");
        else
            $display("wildcard_glob_matcher_test: FAIL");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/gwm_pkg.sv
hw/rtl/gwm_step.sv
hw/rtl/wildcard_glob_matcher.sv
dv/wildcard_glob_matcher_test.sv
